// ===== hdl/lu_pkg.sv =====
package lu_pkg;

    localparam int MAX_ORDER_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int CFG_W         = 5;
    localparam int CMD_W         = 2;
    localparam int POS_W         = 4;
    localparam int STATUS_W      = 2;
    localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

    // request commands
    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SOLVE  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_PIVOT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATURATED  = 2'd2;

    // wide accumulator limit, +-(2^63 - 1)
    localparam logic signed [64:0] ACC_LIM = 65'sh0_7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ISSUE,
        S_MUL,
        S_ACC,
        S_FIN1,
        S_FIN2,
        S_DIVS,
        S_DIVW,
        S_WR,
        S_ORD,
        S_OSHOW,
        S_OWAIT
    } state_t;

    typedef enum logic [1:0] {
        PH_UPPER,
        PH_LOWER,
        PH_FWD,
        PH_BACK
    } phase_t;

    typedef struct packed {
        logic clr;
        logic mul;
        logic acc;
        logic res;
        logic sat_clr;
    } mac_ctrl_t;

endpackage

// ===== hdl/lu_ram.sv =====
module lu_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lu_mac.sv =====
module lu_mac #(
    parameter int FRAC_BITS = lu_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lu_pkg::mac_ctrl_t                ctrl,
    input  logic signed [lu_pkg::DATA_W-1:0] a,
    input  logic signed [lu_pkg::DATA_W-1:0] b,
    input  logic signed [lu_pkg::DATA_W-1:0] base,
    output logic signed [lu_pkg::DATA_W-1:0] res,
    output logic                             sat
);
    import lu_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] res_reg;
    logic               sat_reg;

    logic signed [64:0] sum_a;
    logic signed [63:0] acc_next;
    logic               acc_sat;
    logic signed [63:0] base_sh;
    logic signed [63:0] neg_acc;
    logic signed [64:0] sum_r;
    logic signed [63:0] t_val;
    logic               t_sat;
    logic signed [63:0] shifted;
    logic signed [31:0] res_next;
    logic               res_sat;

    // saturating accumulate of the registered product
    always_comb
    begin
        sum_a   = {acc_reg[63], acc_reg} + {prod_reg[63], prod_reg};
        acc_sat = 1'b0;
        if (sum_a > ACC_LIM)
        begin
            acc_next = ACC_LIM[63:0];
            acc_sat  = 1'b1;
        end
        else if (sum_a < -ACC_LIM)
        begin
            acc_next = -ACC_LIM[63:0];
            acc_sat  = 1'b1;
        end
        else
        begin
            acc_next = sum_a[63:0];
        end
    end

    // residual: base minus sum, floor shift, clamp to 32 bits
    always_comb
    begin
        base_sh = 64'(base) <<< FRAC_BITS;
        neg_acc = -acc_reg;
        sum_r   = {base_sh[63], base_sh} + {neg_acc[63], neg_acc};
        t_sat   = 1'b0;
        if (sum_r > ACC_LIM)
        begin
            t_val = ACC_LIM[63:0];
            t_sat = 1'b1;
        end
        else if (sum_r < -ACC_LIM)
        begin
            t_val = -ACC_LIM[63:0];
            t_sat = 1'b1;
        end
        else
        begin
            t_val = sum_r[63:0];
        end
        shifted = t_val >>> FRAC_BITS;
        res_sat = 1'b0;
        if (shifted > 64'sh0000_0000_7FFF_FFFF)
        begin
            res_next = 32'sh7FFF_FFFF;
            res_sat  = 1'b1;
        end
        else if (shifted < -64'sh0000_0000_8000_0000)
        begin
            res_next = 32'sh8000_0000;
            res_sat  = 1'b1;
        end
        else
        begin
            res_next = shifted[31:0];
        end
    end

    // product, accumulator and residual registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= a * b;
        end
        if (ctrl.clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc)
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.res)
        begin
            res_reg <= res_next;
        end
    end

    // sticky saturation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else if (ctrl.sat_clr)
        begin
            sat_reg <= 1'b0;
        end
        else if ((ctrl.acc && acc_sat) || (ctrl.res && (t_sat || res_sat)))
        begin
            sat_reg <= 1'b1;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

// ===== hdl/lu_div.sv =====
module lu_div #(
    parameter int FRAC_BITS = lu_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [lu_pkg::DATA_W-1:0] num,
    input  logic signed [lu_pkg::DATA_W-1:0] den,
    output logic                             busy,
    output logic signed [lu_pkg::DATA_W-1:0] quo,
    output logic                             sat
);
    import lu_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] q_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic          neg_reg;

    logic [32:0]   num_ext;
    logic [32:0]   den_ext;
    logic [32:0]   num_abs;
    logic [32:0]   den_abs;
    logic [32:0]   rem_sh;
    logic [32:0]   rem_sub;
    logic          ge;

    // magnitudes of the operands and the trial subtraction
    always_comb
    begin
        num_ext = {num[31], num};
        den_ext = {den[31], den};
        num_abs = num[31] ? -num_ext : num_ext;
        den_abs = den[31] ? -den_ext : den_ext;
        rem_sh  = {rem_reg, num_reg[NW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = (rem_sh >= {1'b0, den_reg});
    end

    // control: one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // restoring division datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= NW'(num_abs[31:0]) << FRAC_BITS;
            den_reg <= den_abs[31:0];
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= num[31] ^ den[31];
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    // apply sign and clamp to 32 bits
    always_comb
    begin
        if (neg_reg)
        begin
            sat = (q_reg > NW'(33'h0_8000_0000));
            quo = sat ? 32'sh8000_0000 : -q_reg[31:0];
        end
        else
        begin
            sat = (q_reg > NW'(32'h7FFF_FFFF));
            quo = sat ? 32'sh7FFF_FFFF : q_reg[31:0];
        end
    end

    assign busy = busy_reg;

endmodule

// ===== hdl/lu_linear_solver_core.sv =====
// Load requests (matrix or right-hand-side element) are taken one per cycle, back to back,
// while the sequencer is idle. A solve request runs on one shared multiply-accumulate unit,
// each product term passing through issue, multiply and accumulate states, with quotients
// from the bit-serial divider; at the end the results leave one at a time, each held until taken.
// Reset clears the sequencer and the output valid flag and sets the order to 16; the element
// stores are not cleared.
module lu_linear_solver_core #(
    parameter int MAX_ORDER = lu_pkg::MAX_ORDER_DEF,
    parameter int FRAC_BITS = lu_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lu_pkg::CFG_W-1:0]           cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lu_pkg::CMD_W-1:0]           cmd,
    input  logic [lu_pkg::POS_W-1:0]           row,
    input  logic [lu_pkg::POS_W-1:0]           col,
    input  logic signed [lu_pkg::DATA_W-1:0]   value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lu_pkg::POS_W-1:0]           index,
    output logic signed [lu_pkg::DATA_W-1:0]   solution,
    output logic [lu_pkg::STATUS_W-1:0]        status,
    output logic                               last
);
    import lu_pkg::*;

    localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W  = $clog2(MAX_ORDER + 1);
    localparam int MDEPTH = MAX_ORDER * MAX_ORDER;
    localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

    function automatic logic [MAW-1:0] mat_addr(input logic [CNT_W-1:0] r,
                                                input logic [CNT_W-1:0] c);
        return MAW'(r * MAX_ORDER + c);
    endfunction

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [CFG_W-1:0]   size_reg;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   ie_reg, ie_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   oi_reg, oi_next;
    logic signed [31:0] piv_reg, piv_next;
    logic signed [31:0] den_reg, den_next;
    logic               div_sat_reg, div_sat_next;
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   index_reg, index_next;
    logic signed [31:0] sol_reg, sol_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic               last_reg, last_next;

    logic [CNT_W-1:0]   ie_inc, j_inc, kstart, kend, row_c, col_c;
    logic [CNT_W-1:0]   ld_row, ld_col;
    logic               in_fire, ld_ok;

    logic               mat_we, rhs_we, lo_we, up_we, fwd_we, sol_we;
    logic [MAW-1:0]     mat_raddr, lo_raddr, up_raddr, mat_waddr, lu_waddr;
    logic [IDX_W-1:0]   rhs_raddr, fwd_raddr, sol_raddr, vec_waddr, rhs_waddr;
    logic [31:0]        mat_q, rhs_q, lo_q, up_q, fwd_q, sol_q;
    logic signed [31:0] wr_val;

    mac_ctrl_t          mac_ctrl;
    logic signed [31:0] mac_a, mac_b, mac_base, mac_res;
    logic               mac_sat;
    logic               div_start, div_busy, div_sat;
    logic signed [31:0] div_quo;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign ld_row    = CNT_W'(row);
    assign ld_col    = CNT_W'(col);
    assign ld_ok     = (32'(row) < MAX_ORDER) && (32'(col) < MAX_ORDER);

    // load writes into the matrix and right-hand-side stores
    assign mat_we    = in_fire && (cmd == CMD_LOAD_A) && ld_ok;
    assign rhs_we    = in_fire && (cmd == CMD_LOAD_B) && (32'(row) < MAX_ORDER);
    assign mat_waddr = mat_addr(ld_row, ld_col);
    assign rhs_waddr = IDX_W'(row);

    // loop bounds and element position for the current phase
    always_comb
    begin
        ie_inc = ie_reg + 1'b1;
        j_inc  = j_reg + 1'b1;
        row_c  = (phase_reg == PH_UPPER) ? j_reg : ie_reg;
        col_c  = (phase_reg == PH_UPPER) ? ie_reg : j_reg;
        case (phase_reg)
            PH_FWD:
            begin
                kstart = '0;
                kend   = ie_reg;
            end
            PH_BACK:
            begin
                kstart = ie_inc;
                kend   = n_reg;
            end
            default:
            begin
                kstart = '0;
                kend   = j_reg;
            end
        endcase
    end

    // operand selection for the shared unit
    always_comb
    begin
        mac_a = (phase_reg == PH_BACK) ? up_q : lo_q;
        case (phase_reg)
            PH_FWD:
            begin
                mac_b    = fwd_q;
                mac_base = rhs_q;
            end
            PH_BACK:
            begin
                mac_b    = sol_q;
                mac_base = fwd_q;
            end
            default:
            begin
                mac_b    = up_q;
                mac_base = mat_q;
            end
        endcase
    end

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_UPPER;
            out_valid_reg <= 1'b0;
            div_sat_reg   <= 1'b0;
            n_reg         <= '0;
            j_reg         <= '0;
            ie_reg        <= '0;
            k_reg         <= '0;
            oi_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            div_sat_reg   <= div_sat_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            ie_reg        <= ie_next;
            k_reg         <= k_next;
            oi_reg        <= oi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        piv_reg    <= piv_next;
        den_reg    <= den_next;
        index_reg  <= index_next;
        sol_reg    <= sol_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // next state, addresses and strobes
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        ie_next        = ie_reg;
        k_next         = k_reg;
        oi_next        = oi_reg;
        piv_next       = piv_reg;
        den_next       = den_reg;
        div_sat_next   = div_sat_reg;
        out_valid_next = out_valid_reg;
        index_next     = index_reg;
        sol_next       = sol_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        mac_ctrl       = '0;
        div_start      = 1'b0;
        mat_raddr      = '0;
        lo_raddr       = '0;
        up_raddr       = '0;
        rhs_raddr      = '0;
        fwd_raddr      = '0;
        sol_raddr      = '0;
        lo_we          = 1'b0;
        up_we          = 1'b0;
        fwd_we         = 1'b0;
        sol_we         = 1'b0;
        lu_waddr       = mat_addr(row_c, col_c);
        vec_waddr      = IDX_W'(ie_reg);
        wr_val         = ((phase_reg == PH_LOWER) || (phase_reg == PH_BACK)) ? div_quo : mac_res;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (cmd == CMD_SOLVE))
                begin
                    if (size_reg == '0)
                    begin
                        n_next = CNT_W'(1);
                    end
                    else if (32'(size_reg) > MAX_ORDER)
                    begin
                        n_next = CNT_W'(MAX_ORDER);
                    end
                    else
                    begin
                        n_next = CNT_W'(size_reg);
                    end
                    mac_ctrl.sat_clr = 1'b1;
                    div_sat_next     = 1'b0;
                    phase_next       = PH_UPPER;
                    j_next           = '0;
                    ie_next          = '0;
                    state_next       = S_START;
                end
            end
            S_START:
            begin
                mac_ctrl.clr = 1'b1;
                k_next       = kstart;
                state_next   = S_ISSUE;
            end
            S_ISSUE:
            begin
                // read both operands of term k
                case (phase_reg)
                    PH_FWD:
                    begin
                        lo_raddr  = mat_addr(ie_reg, k_reg);
                        fwd_raddr = IDX_W'(k_reg);
                    end
                    PH_BACK:
                    begin
                        up_raddr  = mat_addr(ie_reg, k_reg);
                        sol_raddr = IDX_W'(k_reg);
                    end
                    default:
                    begin
                        lo_raddr = mat_addr(row_c, k_reg);
                        up_raddr = mat_addr(k_reg, col_c);
                    end
                endcase
                state_next = (k_reg == kend) ? S_FIN1 : S_MUL;
            end
            S_MUL:
            begin
                mac_ctrl.mul = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                mac_ctrl.acc = 1'b1;
                k_next       = k_reg + 1'b1;
                state_next   = S_ISSUE;
            end
            S_FIN1:
            begin
                // fetch the base element and, on the way back, the diagonal
                case (phase_reg)
                    PH_FWD:
                    begin
                        rhs_raddr = IDX_W'(ie_reg);
                    end
                    PH_BACK:
                    begin
                        fwd_raddr = IDX_W'(ie_reg);
                        up_raddr  = mat_addr(ie_reg, ie_reg);
                    end
                    default:
                    begin
                        mat_raddr = mat_addr(row_c, col_c);
                    end
                endcase
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                mac_ctrl.res = 1'b1;
                den_next     = (phase_reg == PH_LOWER) ? piv_reg : up_q;
                if ((phase_reg == PH_LOWER) || (phase_reg == PH_BACK))
                begin
                    state_next = S_DIVS;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_DIVS:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (!div_busy)
                begin
                    state_next = S_WR;
                    if (div_sat)
                    begin
                        div_sat_next = 1'b1;
                    end
                end
            end
            S_WR:
            begin
                state_next = S_START;
                unique case (phase_reg)
                    PH_UPPER:
                    begin
                        up_we = 1'b1;
                        if (ie_reg == j_reg)
                        begin
                            piv_next = mac_res;
                        end
                        if ((ie_reg == j_reg) && (mac_res == '0))
                        begin
                            // zero pivot: one error result
                            out_valid_next = 1'b1;
                            index_next     = POS_W'(j_reg);
                            sol_next       = '0;
                            status_next    = ST_ZERO_PIVOT;
                            last_next      = 1'b1;
                            state_next     = S_OWAIT;
                        end
                        else if (ie_inc < n_reg)
                        begin
                            ie_next = ie_inc;
                        end
                        else if (j_inc < n_reg)
                        begin
                            phase_next = PH_LOWER;
                            ie_next    = j_inc;
                        end
                        else
                        begin
                            phase_next = PH_FWD;
                            ie_next    = '0;
                        end
                    end
                    PH_LOWER:
                    begin
                        lo_we = 1'b1;
                        if (ie_inc < n_reg)
                        begin
                            ie_next = ie_inc;
                        end
                        else
                        begin
                            phase_next = PH_UPPER;
                            j_next     = j_inc;
                            ie_next    = j_inc;
                        end
                    end
                    PH_FWD:
                    begin
                        fwd_we = 1'b1;
                        if (ie_inc < n_reg)
                        begin
                            ie_next = ie_inc;
                        end
                        else
                        begin
                            phase_next = PH_BACK;
                            ie_next    = n_reg - 1'b1;
                        end
                    end
                    PH_BACK:
                    begin
                        sol_we = 1'b1;
                        if (ie_reg == '0)
                        begin
                            oi_next    = '0;
                            state_next = S_ORD;
                        end
                        else
                        begin
                            ie_next = ie_reg - 1'b1;
                        end
                    end
                endcase
            end
            S_ORD:
            begin
                sol_raddr  = IDX_W'(oi_reg);
                state_next = S_OSHOW;
            end
            S_OSHOW:
            begin
                out_valid_next = 1'b1;
                index_next     = POS_W'(oi_reg);
                sol_next       = sol_q;
                status_next    = (mac_sat || div_sat_reg) ? ST_SATURATED : ST_OK;
                last_next      = (oi_reg == n_reg - 1'b1);
                state_next     = S_OWAIT;
            end
            S_OWAIT:
            begin
                // hold the result until taken
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oi_next    = oi_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    lu_ram #(.W(DATA_W), .DEPTH(MDEPTH), .AW(MAW)) u_mat (
        .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(value),
        .raddr(mat_raddr), .rdata(mat_q)
    );

    lu_ram #(.W(DATA_W), .DEPTH(MAX_ORDER), .AW(IDX_W)) u_rhs (
        .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(value),
        .raddr(rhs_raddr), .rdata(rhs_q)
    );

    lu_ram #(.W(DATA_W), .DEPTH(MDEPTH), .AW(MAW)) u_lower (
        .clk(clk), .we(lo_we), .waddr(lu_waddr), .wdata(wr_val),
        .raddr(lo_raddr), .rdata(lo_q)
    );

    lu_ram #(.W(DATA_W), .DEPTH(MDEPTH), .AW(MAW)) u_upper (
        .clk(clk), .we(up_we), .waddr(lu_waddr), .wdata(wr_val),
        .raddr(up_raddr), .rdata(up_q)
    );

    lu_ram #(.W(DATA_W), .DEPTH(MAX_ORDER), .AW(IDX_W)) u_fwd (
        .clk(clk), .we(fwd_we), .waddr(vec_waddr), .wdata(wr_val),
        .raddr(fwd_raddr), .rdata(fwd_q)
    );

    lu_ram #(.W(DATA_W), .DEPTH(MAX_ORDER), .AW(IDX_W)) u_sol (
        .clk(clk), .we(sol_we), .waddr(vec_waddr), .wdata(wr_val),
        .raddr(sol_raddr), .rdata(sol_q)
    );

    lu_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk(clk), .rst_n(rst_n), .ctrl(mac_ctrl), .a(mac_a), .b(mac_b),
        .base(mac_base), .res(mac_res), .sat(mac_sat)
    );

    lu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(mac_res), .den(den_reg),
        .busy(div_busy), .quo(div_quo), .sat(div_sat)
    );

    assign out_valid = out_valid_reg;
    assign index     = index_reg;
    assign solution  = sol_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ===== bench/tb_lu_linear_solver_core.sv =====
module tb_lu_linear_solver_core;
    import lu_pkg::*;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ONE_FX  = 64'sd65536;
    localparam int     ORDER   = 16;
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } solver_req_t;

    typedef struct {
        logic [POS_W-1:0]         idx;
        logic signed [DATA_W-1:0] sol;
        logic [STATUS_W-1:0]      st;
        logic                     fin;
    } solution_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [CMD_W-1:0]           cmd;
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           col;
    logic signed [DATA_W-1:0]   value;
    logic                       out_valid;
    logic                       out_ready;
    logic [POS_W-1:0]           index;
    logic signed [DATA_W-1:0]   solution;
    logic [STATUS_W-1:0]        status;
    logic                       last;

    solver_req_t pending_reqs[$];
    solution_t   solutions_due[$];

    // predictor image of the block
    int          mat_img [0:ORDER*ORDER-1];
    int          rhs_img [0:ORDER-1];
    logic [4:0]  order_img;
    bit          sat_flag;

    // stimulus bookkeeping
    int          reqs_made;
    int          reqs_taken;
    bit          req_done;
    bit          cfg_done;
    bit          calm;
    int          in_gap;
    int          out_gap;
    int          errors;

    lu_linear_solver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .index     (index),
        .solution  (solution),
        .status    (status),
        .last      (last)
    );

    always #2 clk = ~clk;

    // fixed-point helpers, saturating
    function automatic int clip32(longint v);
        if (v > I32_MAX)
        begin
            sat_flag = 1;
            return int'(I32_MAX);
        end
        if (v < I32_MIN)
        begin
            sat_flag = 1;
            return int'(I32_MIN);
        end
        return int'(v);
    endfunction

    function automatic longint acc_add(longint a, longint b);
        if (b > 0 && a > ACC_MAX - b)
        begin
            sat_flag = 1;
            return ACC_MAX;
        end
        if (b < 0 && a < ACC_MIN - b)
        begin
            sat_flag = 1;
            return ACC_MIN;
        end
        return a + b;
    endfunction

    function automatic int resid(int base, longint acc);
        longint t;
        t = acc_add(longint'(base) * ONE_FX, -acc);
        return clip32(t >>> FRAC_BITS_DEF);
    endfunction

    function automatic int quot(int num, int den);
        return clip32((longint'(num) * ONE_FX) / longint'(den));
    endfunction

    // factor, substitute and queue the solution elements
    function automatic void predict_solution();
        int      lo [0:ORDER*ORDER-1];
        int      up [0:ORDER*ORDER-1];
        int      fw [0:ORDER-1];
        int      xs [0:ORDER-1];
        int      n;
        longint  acc;
        solution_t s;
        n = order_img;
        if (n < 1) n = 1;
        if (n > ORDER) n = ORDER;
        sat_flag = 0;
        for (int p = 0; p < ORDER*ORDER; p++)
        begin
            lo[p] = 0;
            up[p] = 0;
        end
        for (int p = 0; p < ORDER; p++)
        begin
            fw[p] = 0;
            xs[p] = 0;
        end
        for (int i = 0; i < n; i++)
            lo[i*ORDER+i] = int'(ONE_FX);
        for (int j = 0; j < n; j++)
        begin
            for (int i = j; i < n; i++)
            begin
                acc = 0;
                for (int k = 0; k < j; k++)
                    acc = acc_add(acc, longint'(lo[j*ORDER+k]) * longint'(up[k*ORDER+i]));
                up[j*ORDER+i] = resid(mat_img[j*ORDER+i], acc);
            end
            if (up[j*ORDER+j] == 0)
            begin
                s.idx = j[POS_W-1:0];
                s.sol = '0;
                s.st  = ST_ZERO_PIVOT;
                s.fin = 1'b1;
                solutions_due.push_back(s);
                return;
            end
            for (int i = j + 1; i < n; i++)
            begin
                acc = 0;
                for (int k = 0; k < j; k++)
                    acc = acc_add(acc, longint'(lo[i*ORDER+k]) * longint'(up[k*ORDER+j]));
                lo[i*ORDER+j] = quot(resid(mat_img[i*ORDER+j], acc), up[j*ORDER+j]);
            end
        end
        for (int j = 0; j < n; j++)
        begin
            acc = 0;
            for (int i = 0; i < j; i++)
                acc = acc_add(acc, longint'(lo[j*ORDER+i]) * longint'(fw[i]));
            fw[j] = resid(rhs_img[j], acc);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            acc = 0;
            for (int j = i + 1; j < n; j++)
                acc = acc_add(acc, longint'(up[i*ORDER+j]) * longint'(xs[j]));
            xs[i] = quot(resid(fw[i], acc), up[i*ORDER+i]);
        end
        for (int i = 0; i < n; i++)
        begin
            s.idx = i[POS_W-1:0];
            s.sol = xs[i];
            s.st  = sat_flag ? ST_SATURATED : ST_OK;
            s.fin = (i == n - 1);
            solutions_due.push_back(s);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sample accepted requests, config writes and results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                case (cmd)
                    CMD_LOAD_A: mat_img[row*ORDER+col] = value;
                    CMD_LOAD_B: rhs_img[row] = value;
                    CMD_SOLVE:  predict_solution();
                    default:    ;
                endcase
                reqs_taken++;
                req_done = 1;
            end
            if (cfg_valid && cfg_ready)
            begin
                order_img = cfg_data;
                cfg_done  = 1;
            end
            if (out_valid && out_ready)
            begin
                if (solutions_due.size() == 0)
                begin
                    $error("unexpected result index=%0d solution=%0d", index, solution);
                    errors++;
                end
                else
                begin
                    solution_t s;
                    s = solutions_due.pop_front();
                    if (index !== s.idx)
                    begin
                        $error("index: expected %0d, got %0d", s.idx, index);
                        errors++;
                    end
                    if (solution !== s.sol)
                    begin
                        $error("solution: expected %0d, got %0d", s.sol, solution);
                        errors++;
                    end
                    if (status !== s.st)
                    begin
                        $error("status: expected %0d, got %0d", s.st, status);
                        errors++;
                    end
                    if (last !== s.fin)
                    begin
                        $error("last: expected %0d, got %0d", s.fin, last);
                        errors++;
                    end
                end
            end
        end
    end

    // request driver: advance on acceptance, hold otherwise
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_done))
        begin
            solver_req_t r;
            req_done = 0;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                in_valid <= 1'b1;
                cmd      <= r.cmd;
                row      <= r.row;
                col      <= r.col;
                value    <= r.value;
                in_gap   = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_gap = pick_gap();
            end
        end
    end

    task automatic push_req(logic [CMD_W-1:0] c, int r, int k, int v);
        solver_req_t q;
        q.cmd   = c;
        q.row   = r[POS_W-1:0];
        q.col   = k[POS_W-1:0];
        q.value = v;
        pending_reqs.push_back(q);
        reqs_made++;
    endtask

    // hold until every request is taken and every result has come
    task automatic wait_drained();
        while (reqs_taken != reqs_made || solutions_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_order(int raw);
        wait_drained();
        cfg_done = 0;
        cfg_valid <= 1'b1;
        cfg_data  <= raw[CFG_W-1:0];
        do @(negedge clk); while (!cfg_done);
        cfg_valid <= 1'b0;
    endtask

    function automatic int small_val(int span);
        return int'($urandom_range(0, 2*span)) - span;
    endfunction

    // one system: add noise, load the leading block, then solve, sometimes again with a new right-hand side
    task automatic run_system(int raw, int kind);
        int n;
        int p;
        int v;
        set_order(raw);
        calm = ($urandom_range(0, 4) == 0);
        n = raw < 1 ? 1 : (raw > ORDER ? ORDER : raw);
        p = $urandom_range(0, n - 1);
        for (int i = 0; i < $urandom_range(0, 2); i++)
        begin
            if ($urandom_range(0, 1))
                push_req(CMD_IGNORED, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
            else
                push_req(CMD_LOAD_A, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        end
        for (int i = 0; i < n; i++)
            for (int k = 0; k < n; k++)
            begin
                case (kind)
                    1: v = $urandom;
                    2: v = (k < i) ? 0 : ((k == i) ? (i == p ? 0 : 32'h0001_0000 +
                           small_val(32'h8000)) : small_val(32'h0002_0000));
                    default: v = (i == k) ? 32'h0008_0000 + small_val(32'h0002_0000)
                                          : small_val(32'h0002_0000);
                endcase
                push_req(CMD_LOAD_A, i, k, v);
            end
        for (int i = 0; i < n; i++)
            push_req(CMD_LOAD_B, i, $urandom_range(0, 15),
                     kind == 3 ? int'($urandom) : small_val(32'h0010_0000));
        push_req(CMD_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        // new right-hand side on the same matrix
        if ($urandom_range(0, 2) == 0)
        begin
            push_req(CMD_LOAD_B, $urandom_range(0, n - 1), 0, $urandom);
            push_req(CMD_SOLVE, 0, 0, 0);
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        cmd       = CMD_LOAD_A;
        row       = '0;
        col       = '0;
        value     = '0;
        out_ready = 1'b0;
        order_img = SIZE_RESET;
        reqs_made = 0;
        reqs_taken = 0;
        errors    = 0;
        calm      = 0;
        in_gap    = 0;
        out_gap   = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // order zero behaves as one: zero pivot, extremes, ignored command
        set_order(0);
        push_req(CMD_LOAD_A, 0, 0, 0);
        push_req(CMD_LOAD_B, 0, 0, 32'h7FFF_FFFF);
        push_req(CMD_SOLVE, 0, 0, 0);
        push_req(CMD_LOAD_A, 0, 0, 32'h7FFF_FFFF);
        push_req(CMD_LOAD_B, 0, 0, 32'h8000_0000);
        push_req(CMD_SOLVE, 0, 0, 0);
        push_req(CMD_LOAD_A, 0, 0, 1);
        push_req(CMD_LOAD_B, 0, 0, 32'h7FFF_FFFF);
        push_req(CMD_IGNORED, 15, 15, 32'hFFFF_FFFF);
        push_req(CMD_SOLVE, 15, 15, 32'hFFFF_FFFF);
        push_req(CMD_LOAD_A, 0, 0, 32'h8000_0000);
        push_req(CMD_SOLVE, 0, 0, 0);

        // order two with equal rows: zero pivot on the second row
        set_order(2);
        push_req(CMD_LOAD_A, 0, 0, 32'h0001_0000);
        push_req(CMD_LOAD_A, 0, 1, 32'h0002_0000);
        push_req(CMD_LOAD_A, 1, 0, 32'h0001_0000);
        push_req(CMD_LOAD_A, 1, 1, 32'h0002_0000);
        push_req(CMD_LOAD_B, 1, 0, 32'h0003_0000);
        push_req(CMD_SOLVE, 0, 0, 0);
        push_req(CMD_LOAD_A, 1, 1, 32'h0005_0000);
        push_req(CMD_SOLVE, 0, 0, 0);

        // full order: above the maximum, then the maximum itself on the same system
        run_system(31, 0);
        set_order(16);
        push_req(CMD_SOLVE, 0, 0, 0);
        run_system(1, 0);

        // random systems, mostly small
        while (reqs_made < 410)
        begin
            int k;
            k = $urandom_range(0, 99);
            run_system($urandom_range(0, 6),
                       k < 60 ? 0 : (k < 75 ? 1 : (k < 85 ? 2 : 3)));
        end

        wait_drained();
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
